// File: rtl/rounded_rect_pixel_coverage_macros.svh
// Assertion macros for the rounded-rect coverage checker.
`ifndef ROUNDED_RECT_PIXEL_COVERAGE_MACROS_SVH
`define ROUNDED_RECT_PIXEL_COVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rrpc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rrpc check failed");

`endif

// File: rtl/rrpc_pkg.sv
// Shared types and constants for the rounded-rect pixel coverage block.
`timescale 1ns / 1ps
package rrpc_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam int RECT_W   = 13;  // rect/screen size registers
	localparam int RAD_W    = 12;  // corner radius and corner distances
	localparam int POS_W    = 13;  // signed origin registers
	localparam int SCR_W    = 14;  // signed screen position outputs
	localparam int RAD_SQ_W = 2 * RAD_W;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Stages holding a request: input, classify, square, output.
	localparam int PIPE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_RECT_WIDTH    = 3'd0,
		REG_RECT_HEIGHT   = 3'd1,
		REG_CORNER_RADIUS = 3'd2,
		REG_DRAW_MODE     = 3'd3,
		REG_ORIGIN_X      = 3'd4,
		REG_ORIGIN_Y      = 3'd5,
		REG_SCREEN_WIDTH  = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} reg_idx_t;

endpackage

// File: rtl/rrpc_if.sv
// Valid/ready channels for pixel requests and coverage results.
`timescale 1ns / 1ps
interface rrpc_pixel_if import rrpc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_dx;
	logic [COORD_BITS-1:0] pixel_dy;

	modport source (output valid, output pixel_dx, output pixel_dy, input ready);
	modport sink   (input valid, input pixel_dx, input pixel_dy, output ready);
endinterface

interface rrpc_cover_if import rrpc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    inside_shape;
	logic                    write_pixel;
	logic signed [SCR_W-1:0] screen_x;
	logic signed [SCR_W-1:0] screen_y;

	modport source (output valid, output inside_shape, output write_pixel,
		output screen_x, output screen_y, input ready);
	modport sink   (input valid, input inside_shape, input write_pixel,
		input screen_x, input screen_y, output ready);
endinterface

// File: rtl/rounded_rect_pixel_coverage.sv
// Rounded-rect pixel coverage: classifies one bounding-box offset per clock unless stalled.
//
// Each request on the pixel channel carries an offset (pixel_dx, pixel_dy) inside
// the bounding box of a rectangle; the block answers on the coverage channel with
// whether the rounded rectangle (fill mode) or its one-pixel border (border mode)
// covers that offset, the screen position origin + offset, and write_pixel, which
// is coverage gated by the screen bounds. The corner radius is clamped to half the
// width and half the height with a floor of one; a zero radius gives square
// corners, and border mode on a rectangle narrower or shorter than three pixels
// draws a plain outline. The border's inner shape is inset one pixel with radius
// max(r-1,1). Throughput is one request per clock while the coverage channel
// accepts results, since each stage advances as the one after it moves. The
// four stages are: input register, corner classification (radius clamp and
// corner distances), squaring (six 12x12 multipliers, outer and inner shape), and
// the sum/compare that fills the output register. Each stage advances when the
// one after it is empty or moving, so a stalled result does not stop requests
// from entering while a bubble remains. Configuration registers sit on an APB
// port at byte address 4*index and must only be written while the block is idle.
`timescale 1ns / 1ps
module rounded_rect_pixel_coverage import rrpc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rrpc_pixel_if.sink        pixel,
	rrpc_cover_if.source      coverage
);

	// Signed working width: holds offsets, sizes and their differences.
	localparam int CW = ((COORD_BITS > RECT_W) ? COORD_BITS : RECT_W) + 3;
	localparam logic signed [CW-1:0] ONE_C = CW'(1);
	localparam logic signed [CW-1:0] TWO_C = CW'(2);
	localparam logic [RECT_W-1:0]   THIN_LIM = RECT_W'(3);

	typedef struct packed {
		logic             in_rng;  // offset lies in the box
		logic             core;    // offset lies away from all corners
		logic [RAD_W-1:0] cx;      // distance from corner center, clamped
		logic [RAD_W-1:0] cy;
	} shape_t;

	// Classify one offset against a rounded box; cx/cy only matter when in range.
	function automatic shape_t shape_eval(input logic signed [CW-1:0] ddx,
		input logic signed [CW-1:0] ddy, input logic signed [CW-1:0] ww,
		input logic signed [CW-1:0] hh, input logic signed [CW-1:0] rr);
		logic signed [CW-1:0] cxs;
		logic signed [CW-1:0] cys;
		shape_t               s;
		s.in_rng = (ddx >= 0) && (ddy >= 0) && (ddx < ww) && (ddy < hh);
		s.core   = (ddx >= rr) && (ddx < ww - rr) && (ddy >= rr) && (ddy < hh - rr);
		cxs = (ddx < rr) ? rr - ddx : ddx - (ww - rr - ONE_C);
		cys = (ddy < rr) ? rr - ddy : ddy - (hh - rr - ONE_C);
		if (cxs < 0) cxs = '0;
		if (cys < 0) cys = '0;
		s.cx = cxs[RAD_W-1:0];
		s.cy = cys[RAD_W-1:0];
		return s;
	endfunction

	// ---------------------------------------------------------------- config regs
	logic [RECT_W-1:0] rect_width_q;
	logic [RECT_W-1:0] rect_height_q;
	logic [RAD_W-1:0]  corner_radius_q;
	logic              draw_mode_q;
	logic [POS_W-1:0]  origin_x_q;
	logic [POS_W-1:0]  origin_y_q;
	logic [RECT_W-1:0] screen_width_q;
	logic [RECT_W-1:0] screen_height_q;

	reg_idx_t cfg_idx;
	logic     cfg_wr;

	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_width_q    <= '0;
			rect_height_q   <= '0;
			corner_radius_q <= '0;
			draw_mode_q     <= 1'b0;
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			screen_width_q  <= '0;
			screen_height_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_RECT_WIDTH:    rect_width_q    <= pwdata[RECT_W-1:0];
				REG_RECT_HEIGHT:   rect_height_q   <= pwdata[RECT_W-1:0];
				REG_CORNER_RADIUS: corner_radius_q <= pwdata[RAD_W-1:0];
				REG_DRAW_MODE:     draw_mode_q     <= pwdata[0];
				REG_ORIGIN_X:      origin_x_q      <= pwdata[POS_W-1:0];
				REG_ORIGIN_Y:      origin_y_q      <= pwdata[POS_W-1:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[RECT_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[RECT_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_RECT_WIDTH:    prdata = APB_DW'(rect_width_q);
			REG_RECT_HEIGHT:   prdata = APB_DW'(rect_height_q);
			REG_CORNER_RADIUS: prdata = APB_DW'(corner_radius_q);
			REG_DRAW_MODE:     prdata = APB_DW'(draw_mode_q);
			REG_ORIGIN_X:      prdata = APB_DW'(origin_x_q);
			REG_ORIGIN_Y:      prdata = APB_DW'(origin_y_q);
			REG_SCREEN_WIDTH:  prdata = APB_DW'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = APB_DW'(screen_height_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	// Each stage loads when it is empty or its content moves on.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4        = !valid_s4 || coverage.ready;
	assign adv3        = !valid_s3 || adv4;
	assign adv2        = !valid_s2 || adv3;
	assign adv1        = !valid_s1 || adv2;
	assign pixel.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= pixel.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// ---------------------------------------------------------------- stage 1: input
	logic [COORD_BITS-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			dx_s1 <= pixel.pixel_dx;
			dy_s1 <= pixel.pixel_dy;
		end
	end

	// ---------------------------------------------------------------- classify
	logic signed [CW-1:0] dxw, dyw, ww, hh, rrw, irw, sxw, syw;
	logic [RAD_W-1:0]     r_eff, ir_eff;
	shape_t               outer_c, inner_c;
	logic                 rect_fill, outline, round_en, simple_cov, on_screen;

	always_comb begin
		dxw = $signed({{(CW-COORD_BITS){1'b0}}, dx_s1});
		dyw = $signed({{(CW-COORD_BITS){1'b0}}, dy_s1});
		ww  = $signed({{(CW-RECT_W){1'b0}}, rect_width_q});
		hh  = $signed({{(CW-RECT_W){1'b0}}, rect_height_q});

		// radius clamp: min(r, w/2, h/2), floor of one
		r_eff = corner_radius_q;
		if (rect_width_q[RECT_W-1:1] < r_eff) r_eff = rect_width_q[RECT_W-1:1];
		if (rect_height_q[RECT_W-1:1] < r_eff) r_eff = rect_height_q[RECT_W-1:1];
		if (r_eff == '0) r_eff = RAD_W'(1);
		ir_eff = (r_eff > RAD_W'(1)) ? r_eff - RAD_W'(1) : RAD_W'(1);
		rrw = $signed({{(CW-RAD_W){1'b0}}, r_eff});
		irw = $signed({{(CW-RAD_W){1'b0}}, ir_eff});

		outer_c = shape_eval(dxw, dyw, ww, hh, rrw);
		inner_c = shape_eval(dxw - ONE_C, dyw - ONE_C, ww - TWO_C, hh - TWO_C, irw);

		rect_fill = (dxw < ww) && (dyw < hh);
		outline   = (((dyw == 0) || (dyw == hh - ONE_C)) && (dxw < ww)) ||
		            (((dxw == 0) || (dxw == ww - ONE_C)) && (dyw < hh));
		// rounding off for square corners, or a border too thin to hold an inner shape
		round_en   = (corner_radius_q != '0) &&
		             (!draw_mode_q || ((rect_width_q >= THIN_LIM) &&
		                               (rect_height_q >= THIN_LIM)));
		simple_cov = draw_mode_q ? outline : rect_fill;

		sxw = $signed({{(CW-POS_W){origin_x_q[POS_W-1]}}, origin_x_q}) + dxw;
		syw = $signed({{(CW-POS_W){origin_y_q[POS_W-1]}}, origin_y_q}) + dyw;
		on_screen = (sxw >= 0) && (syw >= 0) &&
		            (sxw < $signed({{(CW-RECT_W){1'b0}}, screen_width_q})) &&
		            (syw < $signed({{(CW-RECT_W){1'b0}}, screen_height_q}));
	end

	// ---------------------------------------------------------------- stage 2
	shape_t           outer_s2, inner_s2;
	logic [RAD_W-1:0] r_s2, ir_s2;
	logic             round_en_s2, border_s2, simple_cov_s2, on_s2;
	logic [SCR_W-1:0] sx_s2, sy_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			outer_s2      <= outer_c;
			inner_s2      <= inner_c;
			r_s2          <= r_eff;
			ir_s2         <= ir_eff;
			round_en_s2   <= round_en;
			border_s2     <= draw_mode_q;
			simple_cov_s2 <= simple_cov;
			on_s2         <= on_screen;
			sx_s2         <= sxw[SCR_W-1:0];
			sy_s2         <= syw[SCR_W-1:0];
		end
	end

	// ---------------------------------------------------------------- squares
	logic [RAD_SQ_W-1:0] ocx_sq, ocy_sq, r_sq, icx_sq, icy_sq, ir_sq;

	assign ocx_sq = RAD_SQ_W'(outer_s2.cx) * RAD_SQ_W'(outer_s2.cx);
	assign ocy_sq = RAD_SQ_W'(outer_s2.cy) * RAD_SQ_W'(outer_s2.cy);
	assign r_sq   = RAD_SQ_W'(r_s2) * RAD_SQ_W'(r_s2);
	assign icx_sq = RAD_SQ_W'(inner_s2.cx) * RAD_SQ_W'(inner_s2.cx);
	assign icy_sq = RAD_SQ_W'(inner_s2.cy) * RAD_SQ_W'(inner_s2.cy);
	assign ir_sq  = RAD_SQ_W'(ir_s2) * RAD_SQ_W'(ir_s2);

	// ---------------------------------------------------------------- stage 3
	logic [RAD_SQ_W-1:0] ocx_sq_s3, ocy_sq_s3, r_sq_s3, icx_sq_s3, icy_sq_s3, ir_sq_s3;
	logic                o_in_s3, o_core_s3, i_in_s3, i_core_s3;
	logic                round_en_s3, border_s3, simple_cov_s3, on_s3;
	logic [SCR_W-1:0]    sx_s3, sy_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			ocx_sq_s3     <= ocx_sq;
			ocy_sq_s3     <= ocy_sq;
			r_sq_s3       <= r_sq;
			icx_sq_s3     <= icx_sq;
			icy_sq_s3     <= icy_sq;
			ir_sq_s3      <= ir_sq;
			o_in_s3       <= outer_s2.in_rng;
			o_core_s3     <= outer_s2.core;
			i_in_s3       <= inner_s2.in_rng;
			i_core_s3     <= inner_s2.core;
			round_en_s3   <= round_en_s2;
			border_s3     <= border_s2;
			simple_cov_s3 <= simple_cov_s2;
			on_s3         <= on_s2;
			sx_s3         <= sx_s2;
			sy_s3         <= sy_s2;
		end
	end

	// ---------------------------------------------------------------- compare
	logic [RAD_SQ_W:0] o_sum, i_sum;
	logic              o_cov, i_cov, cov;

	always_comb begin
		o_sum = {1'b0, ocx_sq_s3} + {1'b0, ocy_sq_s3};
		i_sum = {1'b0, icx_sq_s3} + {1'b0, icy_sq_s3};
		o_cov = o_in_s3 && (o_core_s3 || (o_sum <= {1'b0, r_sq_s3}));
		i_cov = i_in_s3 && (i_core_s3 || (i_sum <= {1'b0, ir_sq_s3}));
		if (!round_en_s3) cov = simple_cov_s3;
		else if (border_s3) cov = o_cov && !i_cov;
		else cov = o_cov;
	end

	// ---------------------------------------------------------------- stage 4: output
	logic             cov_s4, write_s4;
	logic [SCR_W-1:0] sx_s4, sy_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			cov_s4   <= cov;
			write_s4 <= cov && on_s3;
			sx_s4    <= sx_s3;
			sy_s4    <= sy_s3;
		end
	end

	assign coverage.valid        = valid_s4;
	assign coverage.inside_shape = cov_s4;
	assign coverage.write_pixel  = write_s4;
	assign coverage.screen_x     = $signed(sx_s4);
	assign coverage.screen_y     = $signed(sy_s4);

endmodule

// File: rtl/rrpc_checker.sv
// Port-level checker for the rounded-rect coverage block, with its bind.
`timescale 1ns / 1ps
`include "rounded_rect_pixel_coverage_macros.svh"
module rrpc_checker import rrpc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    inside_shape,
	input logic                    write_pixel,
	input logic signed [SCR_W-1:0] screen_x,
	input logic signed [SCR_W-1:0] screen_y
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	`RRPC_ASSERT_IMP(a_no_phantom, clk, arst_n, out_valid, pending_q != '0)
	`RRPC_ASSERT_IMP(a_depth, clk, arst_n, 1'b1, pending_q <= CNT_W'(PIPE_DEPTH))
	`RRPC_ASSERT_IMP(a_write_covered, clk, arst_n, out_valid && write_pixel, inside_shape)
	`RRPC_ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(inside_shape) && $stable(write_pixel) && $stable(screen_x) && $stable(screen_y))

endmodule

bind rounded_rect_pixel_coverage rrpc_checker u_rrpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pixel.valid),
	.in_ready     (pixel.ready),
	.out_valid    (coverage.valid),
	.out_ready    (coverage.ready),
	.inside_shape (coverage.inside_shape),
	.write_pixel  (coverage.write_pixel),
	.screen_x     (coverage.screen_x),
	.screen_y     (coverage.screen_y)
);
